@@ rtl/spf_pkg.sv @@
package spf_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [1:0] CMD_MULTI  = 2'd0;
  localparam logic [1:0] CMD_SINGLE = 2'd1;
  localparam logic [1:0] CMD_TORQUE = 2'd2;

  localparam logic [7:0] SYNC_0       = 8'hFA;
  localparam logic [7:0] SYNC_1       = 8'hAF;
  localparam logic [7:0] FLAG_BYTE    = 8'h00;
  localparam logic [7:0] MULTI_ID     = 8'h00;
  localparam logic [7:0] ADDR_POS     = 8'h1E;
  localparam logic [7:0] ADDR_TORQUE  = 8'h24;
  localparam logic [7:0] ID_BROADCAST = 8'hFF;
  localparam logic [7:0] LEN_MULTI    = 8'h03;
  localparam logic [7:0] LEN_SINGLE   = 8'h02;
  localparam logic [7:0] LEN_TORQUE   = 8'h01;
  localparam logic [7:0] COUNT_ONE    = 8'h01;

  localparam logic [7:0] MULTI_HDR_XOR  = MULTI_ID ^ FLAG_BYTE ^ ADDR_POS ^ LEN_MULTI;
  localparam logic [7:0] SINGLE_HDR_XOR = FLAG_BYTE ^ ADDR_POS ^ LEN_SINGLE ^ COUNT_ONE;
  localparam logic [7:0] TORQUE_HDR_XOR =
    ID_BROADCAST ^ FLAG_BYTE ^ ADDR_TORQUE ^ LEN_TORQUE ^ COUNT_ONE;

  localparam logic [3:0] IDX_START      = 4'd0;
  localparam logic [3:0] IDX_ENTRY      = 4'd7;
  localparam logic [3:0] IDX_MULTI_END  = 4'd9;
  localparam logic [3:0] IDX_MULTI_SUM  = 4'd10;
  localparam logic [3:0] IDX_SINGLE_SUM = 4'd9;
  localparam logic [3:0] IDX_TORQUE_SUM = 4'd8;

  typedef enum logic [1:0] {
    KIND_MULTI,
    KIND_SINGLE,
    KIND_TORQUE
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] first_idx;
    logic [3:0] last_idx;
    logic [7:0] id;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] cnt;
    logic [7:0] sum;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ rtl/spf_if.sv @@
interface spf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  servo_id;
  logic [15:0] position;
  logic [7:0]  servo_count;
  logic        last_entry;
  logic        torque_enable;

  modport source (
    output valid, command, servo_id, position, servo_count, last_entry, torque_enable,
    input  ready
  );
  modport sink (
    input  valid, command, servo_id, position, servo_count, last_entry, torque_enable,
    output ready
  );
endinterface

interface spf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (
    output valid, out_byte, last_byte,
    input  ready
  );
  modport sink (
    input  valid, out_byte, last_byte,
    output ready
  );
endinterface

@@ rtl/spf_front.sv @@
module spf_front (
  input  logic                 clk,
  input  logic                 rst_n,
  spf_in_if.sink               in_ch,
  input  spf_pkg::q_status_t   q_status,
  output logic                 push,
  output spf_pkg::job_t        push_job
);

  logic [7:0] running_xor_r, running_xor_nxt;
  logic       packet_open_r, packet_open_nxt;
  logic       accept;
  logic       emit;
  logic [7:0] lo;
  logic [7:0] hi;
  logic [7:0] base;
  logic [7:0] entry_xor;

  assign in_ch.ready = !q_status.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign lo          = in_ch.position[7:0];
  assign hi          = in_ch.position[15:8];
  assign base        = packet_open_r ? running_xor_r
                                     : (spf_pkg::MULTI_HDR_XOR ^ in_ch.servo_count);
  assign entry_xor   = base ^ in_ch.servo_id ^ lo ^ hi;

  always_comb begin
    running_xor_nxt = running_xor_r;
    packet_open_nxt = packet_open_r;
    emit            = 1'b0;
    push_job.kind      = spf_pkg::KIND_MULTI;
    push_job.first_idx = spf_pkg::IDX_START;
    push_job.last_idx  = spf_pkg::IDX_MULTI_END;
    push_job.id        = in_ch.servo_id;
    push_job.lo        = lo;
    push_job.hi        = hi;
    push_job.cnt       = in_ch.servo_count;
    push_job.sum       = entry_xor;
    case (in_ch.command)
      spf_pkg::CMD_MULTI: begin
        if (packet_open_r || (in_ch.servo_count != 8'd0)) begin
          emit = 1'b1;
          push_job.first_idx = packet_open_r ? spf_pkg::IDX_ENTRY : spf_pkg::IDX_START;
          if (in_ch.last_entry) begin
            push_job.last_idx = spf_pkg::IDX_MULTI_SUM;
            running_xor_nxt   = 8'd0;
            packet_open_nxt   = 1'b0;
          end else begin
            running_xor_nxt = entry_xor;
            packet_open_nxt = 1'b1;
          end
        end
      end
      spf_pkg::CMD_SINGLE: begin
        emit = 1'b1;
        push_job.kind     = spf_pkg::KIND_SINGLE;
        push_job.last_idx = spf_pkg::IDX_SINGLE_SUM;
        push_job.sum      = spf_pkg::SINGLE_HDR_XOR ^ in_ch.servo_id ^ lo ^ hi;
      end
      spf_pkg::CMD_TORQUE: begin
        emit = 1'b1;
        push_job.kind     = spf_pkg::KIND_TORQUE;
        push_job.last_idx = spf_pkg::IDX_TORQUE_SUM;
        push_job.lo       = {7'd0, in_ch.torque_enable};
        push_job.sum      = spf_pkg::TORQUE_HDR_XOR ^ {7'd0, in_ch.torque_enable};
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_xor_r <= 8'd0;
      packet_open_r <= 1'b0;
    end else if (accept) begin
      running_xor_r <= running_xor_nxt;
      packet_open_r <= packet_open_nxt;
    end
  end

endmodule

@@ rtl/spf_queue.sv @@
module spf_queue #(
  parameter int DEPTH = spf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  spf_pkg::job_t      push_job,
  input  logic               pop,
  output spf_pkg::job_t      head_job,
  output spf_pkg::q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  spf_pkg::job_t entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign head_job     = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

@@ rtl/spf_back.sv @@
module spf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  spf_pkg::job_t      head_job,
  input  spf_pkg::q_status_t q_status,
  output logic               pop,
  spf_out_if.source          out_ch
);

  function automatic logic [7:0] job_byte(spf_pkg::job_t job, logic [3:0] idx);
    logic [7:0] b;
    b = spf_pkg::FLAG_BYTE;
    if (idx == 4'd0) begin
      b = spf_pkg::SYNC_0;
    end else if (idx == 4'd1) begin
      b = spf_pkg::SYNC_1;
    end else begin
      unique case (job.kind)
        spf_pkg::KIND_MULTI: begin
          case (idx)
            4'd2:    b = spf_pkg::MULTI_ID;
            4'd3:    b = spf_pkg::FLAG_BYTE;
            4'd4:    b = spf_pkg::ADDR_POS;
            4'd5:    b = spf_pkg::LEN_MULTI;
            4'd6:    b = job.cnt;
            4'd7:    b = job.id;
            4'd8:    b = job.lo;
            4'd9:    b = job.hi;
            default: b = job.sum;
          endcase
        end
        spf_pkg::KIND_SINGLE: begin
          case (idx)
            4'd2:    b = job.id;
            4'd3:    b = spf_pkg::FLAG_BYTE;
            4'd4:    b = spf_pkg::ADDR_POS;
            4'd5:    b = spf_pkg::LEN_SINGLE;
            4'd6:    b = spf_pkg::COUNT_ONE;
            4'd7:    b = job.lo;
            4'd8:    b = job.hi;
            default: b = job.sum;
          endcase
        end
        spf_pkg::KIND_TORQUE: begin
          case (idx)
            4'd2:    b = spf_pkg::ID_BROADCAST;
            4'd3:    b = spf_pkg::FLAG_BYTE;
            4'd4:    b = spf_pkg::ADDR_TORQUE;
            4'd5:    b = spf_pkg::LEN_TORQUE;
            4'd6:    b = spf_pkg::COUNT_ONE;
            4'd7:    b = job.lo;
            default: b = job.sum;
          endcase
        end
        default: b = job.sum;
      endcase
    end
    return b;
  endfunction

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       started_r;
  logic [3:0] idx_r;
  logic [3:0] idx;
  logic       load;
  logic       at_end;

  assign idx    = started_r ? idx_r : head_job.first_idx;
  assign load   = !q_status.empty && (!out_valid_r || out_ch.ready);
  assign at_end = (idx == head_job.last_idx);
  assign pop    = load && at_end;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.last_byte = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        started_r   <= !at_end;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= job_byte(head_job, idx);
      out_last_r <= at_end;
      idx_r      <= idx + 4'd1;
    end
  end

endmodule

@@ rtl/servo_packet_framer.sv @@
// Servo packet framer: each accepted command becomes a run of packet bytes on the output
// channel, one byte per cycle while the receiver is ready, 3 to 11 bytes per item (a
// multi-servo entry gives 3, 4, 10 or 11, a single position packet 10, a torque packet 9);
// unused commands and a first entry with a zero count are taken and produce nothing. The
// front end classifies each item and keeps the running checksum of an open multi-servo
// packet, so an item is taken in the cycle it arrives while the job queue (QUEUE_DEPTH
// jobs) has room; each job then passes through the queue into the output register, which
// sends one byte per cycle while the receiver is ready, so a new item can be taken before the
// previous one is sent; items that produce nothing go one per cycle while the queue has room.
module servo_packet_framer #(
  parameter int QUEUE_DEPTH = spf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  spf_in_if.sink     in_ch,
  spf_out_if.source  out_ch
);

  spf_pkg::job_t      push_job;
  spf_pkg::job_t      head_job;
  spf_pkg::q_status_t q_status;
  logic               push;
  logic               pop;

  spf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_status (q_status),
    .push     (push),
    .push_job (push_job)
  );

  spf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (q_status)
  );

  spf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_job (head_job),
    .q_status (q_status),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

@@ rtl/spf_checker.sv @@
module spf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last_byte
);

  // A stalled output transfer keeps its byte.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_byte))
    else $error("output byte changed while stalled");

  // Output only starts once an input transfer has been written to the job queue and loaded out.
  a_out_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("output started without a preceding input transfer");

  // Reset leaves nothing to send.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid straight after reset");

endmodule

bind servo_packet_framer spf_checker u_spf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .last_byte (out_ch.last_byte)
);

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [7:0] HDR_SYNC_A    = 8'hFA;
  localparam logic [7:0] HDR_SYNC_B    = 8'hAF;
  localparam logic [7:0] HDR_FLAG      = 8'h00;
  localparam logic [7:0] HDR_MULTI_ID  = 8'h00;
  localparam logic [7:0] REG_POSITION  = 8'h1E;
  localparam logic [7:0] REG_TORQUE    = 8'h24;
  localparam logic [7:0] ID_ALL        = 8'hFF;
  localparam logic [7:0] LEN_ENTRY     = 8'h03;
  localparam logic [7:0] LEN_POSITION  = 8'h02;
  localparam logic [7:0] LEN_ONOFF     = 8'h01;
  localparam logic [7:0] ONE_SERVO     = 8'h01;

  localparam int RANDOM_ITEMS = 330;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 250;
  localparam int HOLD_AT_ITEM = 40;
  localparam int CALM_FROM    = 120;
  localparam int CALM_TO      = 180;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  servo_id;
    logic [15:0] position;
    logic [7:0]  servo_count;
    logic        last_entry;
    logic        torque_enable;
  } servo_cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } tx_byte_t;

  logic clk;
  logic rst_n;

  spf_in_if  in_ch ();
  spf_out_if out_ch ();

  servo_packet_framer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  servo_cmd_t cmd_backlog [$];
  tx_byte_t   tx_bytes_due [$];
  servo_cmd_t next_cmd;
  tx_byte_t   due_byte;

  logic [7:0] multi_sum;
  logic       multi_open;
  int         items_total;
  int         items_taken;
  int         mismatches;
  int         cycles;
  int         hold_left;
  logic       hold_fired;
  logic       calm;

  assign calm = (items_taken >= CALM_FROM) && (items_taken < CALM_TO);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic send_byte(input logic [7:0] b);
    tx_byte_t t;
    t.data = b;
    t.fin  = 1'b0;
    tx_bytes_due = {tx_bytes_due, t};
  endtask

  task automatic frame_command(input servo_cmd_t c);
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] sum;
    int         base;
    lo = c.position[7:0];
    hi = c.position[15:8];
    base = tx_bytes_due.size();
    case (c.command)
      spf_pkg::CMD_MULTI: begin
        if (multi_open || c.servo_count != 8'd0) begin
          if (!multi_open) begin
            send_byte(HDR_SYNC_A);
            send_byte(HDR_SYNC_B);
            send_byte(HDR_MULTI_ID);
            send_byte(HDR_FLAG);
            send_byte(REG_POSITION);
            send_byte(LEN_ENTRY);
            send_byte(c.servo_count);
            multi_sum = HDR_MULTI_ID ^ HDR_FLAG ^ REG_POSITION ^ LEN_ENTRY ^ c.servo_count;
            multi_open = 1'b1;
          end
          send_byte(c.servo_id);
          send_byte(lo);
          send_byte(hi);
          multi_sum = multi_sum ^ c.servo_id ^ lo ^ hi;
          if (c.last_entry) begin
            send_byte(multi_sum);
            multi_sum = 8'd0;
            multi_open = 1'b0;
          end
        end
      end
      spf_pkg::CMD_SINGLE: begin
        send_byte(HDR_SYNC_A);
        send_byte(HDR_SYNC_B);
        send_byte(c.servo_id);
        send_byte(HDR_FLAG);
        send_byte(REG_POSITION);
        send_byte(LEN_POSITION);
        send_byte(ONE_SERVO);
        send_byte(lo);
        send_byte(hi);
        sum = c.servo_id ^ HDR_FLAG ^ REG_POSITION ^ LEN_POSITION ^ ONE_SERVO ^ lo ^ hi;
        send_byte(sum);
      end
      spf_pkg::CMD_TORQUE: begin
        send_byte(HDR_SYNC_A);
        send_byte(HDR_SYNC_B);
        send_byte(ID_ALL);
        send_byte(HDR_FLAG);
        send_byte(REG_TORQUE);
        send_byte(LEN_ONOFF);
        send_byte(ONE_SERVO);
        send_byte({7'd0, c.torque_enable});
        sum = ID_ALL ^ HDR_FLAG ^ REG_TORQUE ^ LEN_ONOFF ^ ONE_SERVO ^ {7'd0, c.torque_enable};
        send_byte(sum);
      end
      default: ;
    endcase
    if (tx_bytes_due.size() > base) begin
      tx_bytes_due[tx_bytes_due.size() - 1].fin = 1'b1;
    end
  endtask

  task automatic queue_cmd(input logic [1:0] c, input logic [7:0] id, input logic [15:0] pos,
                           input logic [7:0] cnt, input logic le, input logic tq);
    servo_cmd_t item;
    item = '{command: c, servo_id: id, position: pos, servo_count: cnt,
             last_entry: le, torque_enable: tq};
    cmd_backlog = {cmd_backlog, item};
  endtask

  task automatic queue_random_side_cmd();
    int pick;
    pick = $urandom_range(2);
    if (pick == 0) begin
      queue_cmd(spf_pkg::CMD_SINGLE, 8'($urandom_range(255)), 16'($urandom_range(65535)),
                8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
    end else if (pick == 1) begin
      queue_cmd(spf_pkg::CMD_TORQUE, 8'($urandom_range(255)), 16'($urandom_range(65535)),
                8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
    end else begin
      queue_cmd(CMD_UNUSED, 8'($urandom_range(255)), 16'($urandom_range(65535)),
                8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  task automatic queue_multi_packet();
    int  entries;
    int  k;
    logic closes;
    entries = $urandom_range(1, 6);
    closes = ($urandom_range(99) >= 10);
    for (k = 0; k < entries; k++) begin
      if ($urandom_range(99) < 15) begin
        queue_random_side_cmd();
      end
      queue_cmd(spf_pkg::CMD_MULTI, 8'($urandom_range(255)), 16'($urandom_range(65535)),
                (k == 0) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(255)),
                closes && (k == entries - 1), 1'($urandom_range(1)));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      items_taken <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        frame_command('{command: in_ch.command, servo_id: in_ch.servo_id,
                        position: in_ch.position, servo_count: in_ch.servo_count,
                        last_entry: in_ch.last_entry, torque_enable: in_ch.torque_enable});
        items_taken <= items_taken + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (cmd_backlog.size() != 0 && (calm || $urandom_range(99) >= 22)) begin
          next_cmd = cmd_backlog.pop_front();
          in_ch.command       <= next_cmd.command;
          in_ch.servo_id      <= next_cmd.servo_id;
          in_ch.position      <= next_cmd.position;
          in_ch.servo_count   <= next_cmd.servo_count;
          in_ch.last_entry    <= next_cmd.last_entry;
          in_ch.torque_enable <= next_cmd.torque_enable;
          in_ch.valid         <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // The receiver holds off once for a long stretch so that the job queue fills.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_fired <= 1'b0;
    end else if (!hold_fired && items_taken >= HOLD_AT_ITEM) begin
      hold_left <= HOLD_CYCLES;
      hold_fired <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 22);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (tx_bytes_due.size() == 0) begin
        $error("byte %h with last_byte %b arrived with nothing expected",
               out_ch.out_byte, out_ch.last_byte);
        mismatches++;
      end else begin
        due_byte = tx_bytes_due.pop_front();
        if (out_ch.out_byte !== due_byte.data) begin
          $error("out_byte expected %h actual %h", due_byte.data, out_ch.out_byte);
          mismatches++;
        end
        if (out_ch.last_byte !== due_byte.fin) begin
          $error("last_byte expected %b actual %b", due_byte.fin, out_ch.last_byte);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("servo_packet_framer regression: fail");
      $finish;
    end
  end

  initial begin
    int pick;
    clk = 1'b0;
    rst_n = 1'b0;
    cycles = 0;
    mismatches = 0;
    multi_sum = 8'd0;
    multi_open = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = spf_pkg::CMD_MULTI;
    in_ch.servo_id = 8'd0;
    in_ch.position = 16'd0;
    in_ch.servo_count = 8'd0;
    in_ch.last_entry = 1'b0;
    in_ch.torque_enable = 1'b0;
    out_ch.ready = 1'b0;

    // One entry that both opens and closes a packet, then the ignored cases.
    queue_cmd(spf_pkg::CMD_MULTI, 8'h00, 16'h0000, 8'd1, 1'b1, 1'b0);
    queue_cmd(spf_pkg::CMD_MULTI, 8'h12, 16'h3456, 8'd0, 1'b0, 1'b1);
    queue_cmd(spf_pkg::CMD_MULTI, 8'hFF, 16'hFFFF, 8'd0, 1'b1, 1'b1);
    queue_cmd(CMD_UNUSED, 8'h00, 16'h0000, 8'd0, 1'b0, 1'b0);
    queue_cmd(CMD_UNUSED, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
    // Open packet interrupted by whole packets, which leave its checksum alone.
    queue_cmd(spf_pkg::CMD_MULTI, 8'hFF, 16'hFFFF, 8'd255, 1'b0, 1'b1);
    queue_cmd(spf_pkg::CMD_MULTI, 8'h01, 16'h8000, 8'd0, 1'b0, 1'b0);
    queue_cmd(spf_pkg::CMD_SINGLE, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
    queue_cmd(spf_pkg::CMD_TORQUE, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b1);
    queue_cmd(CMD_UNUSED, 8'h55, 16'h1234, 8'h00, 1'b1, 1'b0);
    queue_cmd(spf_pkg::CMD_MULTI, 8'h80, 16'h00FF, 8'h7F, 1'b1, 1'b0);
    queue_cmd(spf_pkg::CMD_TORQUE, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, 1'b0);
    queue_cmd(spf_pkg::CMD_TORQUE, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b1);
    queue_cmd(spf_pkg::CMD_SINGLE, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b0);
    queue_cmd(spf_pkg::CMD_SINGLE, 8'h5A, 16'hA55A, 8'h01, 1'b0, 1'b0);
    // More entries than the count announces; the count is not checked.
    queue_cmd(spf_pkg::CMD_MULTI, 8'h03, 16'h0102, 8'd1, 1'b0, 1'b0);
    queue_cmd(spf_pkg::CMD_MULTI, 8'h04, 16'hFE01, 8'd200, 1'b0, 1'b1);
    queue_cmd(spf_pkg::CMD_MULTI, 8'h05, 16'h7FFF, 8'd255, 1'b0, 1'b0);
    queue_cmd(spf_pkg::CMD_MULTI, 8'hAA, 16'h55AA, 8'd3, 1'b1, 1'b1);
    queue_cmd(spf_pkg::CMD_MULTI, 8'h10, 16'h2030, 8'd3, 1'b0, 1'b0);
    queue_cmd(spf_pkg::CMD_MULTI, 8'h11, 16'h4050, 8'd9, 1'b0, 1'b0);
    queue_cmd(spf_pkg::CMD_MULTI, 8'h12, 16'h6070, 8'd0, 1'b1, 1'b0);

    while (cmd_backlog.size() < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        queue_multi_packet();
      end else if (pick < 90) begin
        queue_random_side_cmd();
      end else begin
        queue_cmd(spf_pkg::CMD_MULTI, 8'($urandom_range(255)), 16'($urandom_range(65535)),
                  8'd0, 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
    items_total = cmd_backlog.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (items_taken != items_total) @(posedge clk);
    while (tx_bytes_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (mismatches == 0 && tx_bytes_due.size() == 0) begin
      $display("servo_packet_framer regression: pass");
    end else begin
      $display("servo_packet_framer regression: fail");
    end
    $finish;
  end

endmodule
